// ===== hdl/fpwc_pkg.sv =====
// ============================================================================
// fpwc_pkg: shared types and codes of the flash page write combiner
// Command and operation codes, and the flush job handed from front to back.
// ============================================================================
package fpwc_pkg;

    // input commands (s_axis_tuser)
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_FAIL  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // output operation kinds (m_axis_tuser)
    localparam logic [1:0] KIND_ERASE  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_BEAT   = 2'd2;

    // widest page fill (1024 bytes) plus one
    localparam int FILL_W = 11;

    // job queue depth: one entry per page bank
    localparam int QDEPTH = 2;

    // one page flush, fully classified by the front
    typedef struct packed {
        logic [31:0]       start;
        logic [FILL_W-1:0] fill;
        logic              erase;
        logic [31:0]       erase_addr;
        logic [31:0]       total;
        logic              last;
        logic              bank;
    } job_t;

    // back reports a drained bank
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

endpackage

// ===== hdl/fpwc_ram.sv =====
// ============================================================================
// fpwc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module fpwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== hdl/fpwc_queue.sv =====
// ============================================================================
// fpwc_queue: flush job queue
// Short FIFO between the front classifier and the back sequencer.
// ============================================================================
module fpwc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fpwc_pkg::job_t    push_job,
    input  logic              pop,
    output fpwc_pkg::job_t    head,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = $clog2(fpwc_pkg::QDEPTH);
    localparam int CNT_W = $clog2(fpwc_pkg::QDEPTH + 1);

    fpwc_pkg::job_t    entry_reg [fpwc_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fpwc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fpwc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(fpwc_pkg::QDEPTH));
    assign empty = (count_reg == '0);

endmodule

// ===== hdl/fpwc_front.sv =====
// ============================================================================
// fpwc_front: input classifier and page collector
// Accepts commands, writes bytes into a double-banked page buffer, decides
// page closes, sector erases and running totals, and queues flush jobs.
// ============================================================================
module fpwc_front #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096,
    parameter int BEAT_BYTES   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [39:0]            s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    // page buffer write port
    output logic                   ram_we,
    output logic [$clog2(2 * (((PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES) > 1 ?
                  (1 << $clog2((PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES)) : 2))-1:0]
                                   ram_waddr,
    output logic [8*BEAT_BYTES-1:0] ram_wdata,
    // job queue
    output logic                   q_push,
    output fpwc_pkg::job_t         q_job,
    input  logic                   q_full,
    // drained bank from the back
    input  fpwc_pkg::done_t        done
);

    localparam int WORDS   = (PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
    localparam int WORD_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FW      = $clog2(PAGE_BYTES + 1);
    localparam int BP_W    = (BEAT_BYTES > 1) ? $clog2(BEAT_BYTES) : 1;
    localparam int ACC_W   = 8 * BEAT_BYTES;
    localparam logic [31:0] PAGE_MASK   = 32'(PAGE_BYTES - 1);
    localparam logic [31:0] SECTOR_MASK = ~32'(SECTOR_BYTES - 1);

    logic [31:0]      start_reg, start_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [BP_W-1:0]  bpos_reg, bpos_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]      esec_reg, esec_next;
    logic             evalid_reg, evalid_next;
    logic             sticky_reg, sticky_next;
    logic [31:0]      count_reg, count_next;

    logic [1:0]       cmd;
    logic [31:0]      addr;
    logic [7:0]       byte_in;
    logic             contig;
    logic [31:0]      start_eff;
    logic [FW-1:0]    new_fill;
    logic             close;
    logic             alone_close;
    logic [ACC_W-1:0] acc_new;
    logic             do_flush;
    logic             do_write;
    logic [31:0]      jstart;
    logic [FW-1:0]    jfill;
    logic             jlast;
    logic [31:0]      jsector;
    logic             jerase;
    logic [1:0]       done_mask;
    logic [1:0]       push_mask;

    assign cmd     = s_axis_tuser;
    assign addr    = s_axis_tdata[31:0];
    assign byte_in = s_axis_tdata[39:32];

    // classification of the offered item
    always_comb begin
        contig      = (addr == start_reg + 32'(fill_reg));
        start_eff   = (fill_reg == '0) ? addr : start_reg;
        new_fill    = fill_reg + 1'b1;
        close       = (((start_eff + 32'(new_fill)) & PAGE_MASK) == '0) ||
                      (new_fill >= FW'(PAGE_BYTES));
        alone_close = (((addr + 32'd1) & PAGE_MASK) == '0);
        acc_new     = ((bpos_reg == '0) ? '0 : acc_reg) |
                      (ACC_W'(byte_in) << {bpos_reg, 3'b000});
    end

    // accept and action decision
    always_comb begin
        s_axis_tready = 1'b0;
        do_flush      = 1'b0;
        do_write      = 1'b0;
        jstart        = start_reg;
        jfill         = fill_reg;
        jlast         = 1'b1;
        sticky_next   = sticky_reg;
        if (sticky_reg || cmd == fpwc_pkg::CMD_FAIL || cmd == fpwc_pkg::CMD_NONE) begin
            s_axis_tready = 1'b1;
            if (s_axis_tvalid && cmd == fpwc_pkg::CMD_FAIL) begin
                sticky_next = 1'b1;
            end
        end else if (cmd == fpwc_pkg::CMD_FLUSH) begin
            s_axis_tready = (fill_reg == '0) || !q_full;
            do_flush      = s_axis_tvalid && (fill_reg != '0) && !q_full;
        end else if (fill_reg != '0 && !contig) begin
            // close the old run first; the byte is taken on a later cycle
            do_flush = s_axis_tvalid && !q_full;
            jlast    = !alone_close;
        end else begin
            s_axis_tready = !busy_reg[bank_reg] && (!close || !q_full);
            do_write      = s_axis_tvalid && s_axis_tready;
            if (do_write && close) begin
                do_flush = 1'b1;
                jstart   = start_eff;
                jfill    = new_fill;
            end
        end
    end

    // flush job contents
    always_comb begin
        jsector          = jstart & SECTOR_MASK;
        jerase           = !evalid_reg || (jsector != esec_reg);
        q_job.start      = jstart;
        q_job.fill       = fpwc_pkg::FILL_W'(jfill);
        q_job.erase      = jerase;
        q_job.erase_addr = jsector;
        q_job.total      = count_reg + 32'(jfill);
        q_job.last       = jlast;
        q_job.bank       = bank_reg;
    end

    assign q_push    = do_flush;
    assign ram_we    = do_write;
    assign ram_waddr = {bank_reg, word_reg};
    assign ram_wdata = acc_new;

    // state update
    always_comb begin
        start_next  = start_reg;
        fill_next   = fill_reg;
        bank_next   = bank_reg;
        bpos_next   = bpos_reg;
        word_next   = word_reg;
        acc_next    = acc_reg;
        esec_next   = esec_reg;
        evalid_next = evalid_reg;
        count_next  = count_reg;
        done_mask   = done.valid ? (2'b01 << done.bank) : 2'b00;
        push_mask   = do_flush ? (2'b01 << bank_reg) : 2'b00;
        busy_next   = (busy_reg & ~done_mask) | push_mask;
        if (do_write) begin
            acc_next = acc_new;
        end
        if (do_flush) begin
            start_next  = jstart + 32'(jfill);
            fill_next   = '0;
            bank_next   = !bank_reg;
            bpos_next   = '0;
            word_next   = '0;
            count_next  = q_job.total;
            esec_next   = jsector;
            evalid_next = 1'b1;
        end else if (do_write) begin
            start_next = start_eff;
            fill_next  = new_fill;
            if (bpos_reg == BP_W'(BEAT_BYTES - 1)) begin
                bpos_next = '0;
                word_next = word_reg + 1'b1;
            end else begin
                bpos_next = bpos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            fill_reg   <= '0;
            bank_reg   <= 1'b0;
            busy_reg   <= '0;
            bpos_reg   <= '0;
            word_reg   <= '0;
            esec_reg   <= '0;
            evalid_reg <= 1'b0;
            sticky_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            start_reg  <= start_next;
            fill_reg   <= fill_next;
            bank_reg   <= bank_next;
            busy_reg   <= busy_next;
            bpos_reg   <= bpos_next;
            word_reg   <= word_next;
            esec_reg   <= esec_next;
            evalid_reg <= evalid_next;
            sticky_reg <= sticky_next;
            count_reg  <= count_next;
        end
    end

    // beat accumulator is payload only
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

`ifndef SYNTH
    // a job is never pushed into a full queue
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("flush job pushed into full queue");

    // bytes never land in a bank still being drained
    a_write_free_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !busy_reg[bank_reg])
        else $error("page write into busy bank");

    // every flush job carries data
    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_job.fill != '0))
        else $error("empty flush job queued");

    // the back only releases banks that were handed to it
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |-> busy_reg[done.bank])
        else $error("bank released while not busy");
`endif

endmodule

// ===== hdl/fpwc_back.sv =====
// ============================================================================
// fpwc_back: flush sequencer
// Pops flush jobs and emits erase, program header and data beats, reading
// the page bank one beat per cycle, unless the output stalls, into a registered output stage.
// ============================================================================
module fpwc_back #(
    parameter int PAGE_BYTES = 256,
    parameter int BEAT_BYTES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // job queue
    input  fpwc_pkg::job_t         q_head,
    input  logic                   q_empty,
    output logic                   q_pop,
    // page buffer read port
    output logic                   ram_re,
    output logic [$clog2(2 * (((PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES) > 1 ?
                  (1 << $clog2((PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES)) : 2))-1:0]
                                   ram_raddr,
    input  logic [8*BEAT_BYTES-1:0] ram_rdata,
    // drained bank
    output fpwc_pkg::done_t        done,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [143:0]           m_axis_tdata,  // flash_address[31:0], beat_data[95:32],
                                                  // byte_count[104:96], bytes_total[136:105]
    output logic [1:0]             m_axis_tuser,  // op_kind[1:0]
    output logic                   m_axis_tlast
);

    localparam int WORDS  = (PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FILL_W = fpwc_pkg::FILL_W;
    localparam logic [FILL_W-1:0] BEAT_CNT = FILL_W'(BEAT_BYTES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ERASE = 2'd1;
    localparam logic [1:0] ST_HEAD  = 2'd2;
    localparam logic [1:0] ST_BEAT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    fpwc_pkg::job_t    job_reg, job_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [31:0]       addr_reg, addr_next;
    logic [WORD_W-1:0] word_reg, word_next;

    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [31:0]       faddr_reg, faddr_next;
    logic [63:0]       beat_reg, beat_next;
    logic [8:0]        cnt_reg, cnt_next;
    logic [31:0]       total_reg, total_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic [FILL_W-1:0] beat_cnt;
    logic [63:0]       beat_masked;

    assign out_free = !valid_reg || m_axis_tready;
    assign beat_cnt = (rem_reg > BEAT_CNT) ? BEAT_CNT : rem_reg;

    // keep only the valid bytes of the beat
    always_comb begin
        beat_masked = '0;
        for (int j = 0; j < BEAT_BYTES; j++) begin
            if (FILL_W'(j) < beat_cnt) begin
                beat_masked[8*j +: 8] = ram_rdata[8*j +: 8];
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        word_next  = word_reg;
        valid_next = valid_reg && !m_axis_tready;
        kind_next  = kind_reg;
        faddr_next = faddr_reg;
        beat_next  = beat_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = {job_reg.bank, word_reg};
        done.valid = 1'b0;
        done.bank  = job_reg.bank;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    job_next   = q_head;
                    rem_next   = q_head.fill;
                    addr_next  = q_head.start;
                    word_next  = '0;
                    state_next = q_head.erase ? ST_ERASE : ST_HEAD;
                end
            end
            ST_ERASE: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = fpwc_pkg::KIND_ERASE;
                    faddr_next = job_reg.erase_addr;
                    beat_next  = '0;
                    cnt_next   = '0;
                    total_next = job_reg.total;
                    last_next  = 1'b0;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = fpwc_pkg::KIND_HEADER;
                    faddr_next = job_reg.start;
                    beat_next  = '0;
                    cnt_next   = job_reg.fill[8:0];
                    total_next = job_reg.total;
                    last_next  = 1'b0;
                    ram_re     = 1'b1;
                    state_next = ST_BEAT;
                end
            end
            ST_BEAT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = fpwc_pkg::KIND_BEAT;
                    faddr_next = addr_reg;
                    beat_next  = beat_masked;
                    cnt_next   = beat_cnt[8:0];
                    total_next = job_reg.total;
                    if (rem_reg <= BEAT_CNT) begin
                        last_next  = job_reg.last;
                        done.valid = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        last_next  = 1'b0;
                        rem_next   = rem_reg - BEAT_CNT;
                        addr_next  = addr_reg + 32'(BEAT_BYTES);
                        word_next  = word_reg + 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = {job_reg.bank, word_reg + 1'b1};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // job context and output payload
    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        rem_reg   <= rem_next;
        addr_reg  <= addr_next;
        word_reg  <= word_next;
        kind_reg  <= kind_next;
        faddr_reg <= faddr_next;
        beat_reg  <= beat_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        last_reg  <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'b0, total_reg, cnt_reg, beat_reg, faddr_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ===== hdl/flash_page_write_combiner.sv =====
// ============================================================================
// flash_page_write_combiner: page program buffer for serial NOR flash
// Collects ascending contiguous bytes into pages and emits sector erase,
// page program header and data beat operations.
// ============================================================================
//
//  channel  | direction | tdata                              | tuser    | tlast
//  ---------+-----------+------------------------------------+----------+----------------
//  s_axis   | in        | address, data_byte                 | command  | -
//  m_axis   | out       | flash_address, beat_data,          | op_kind  | final result
//           |           | byte_count, bytes_total            |          | of one input
//
//  A data byte that extends the current page is taken once its bank is free and,
//  on a page close, the queue has room; a byte that breaks contiguity is held
//  until the old page is queued. A flush drains at one result per cycle unless
//  the output stalls: erase (when needed), header, then ceil(fill / BEAT_BYTES)
//  beats. Two page banks and a two-entry job queue let the front keep collecting
//  while the back drains; the front waits on the back only when both banks are
//  busy. Synchronous active-low reset; no clearing pass, the page banks are
//  written before they are read. PAGE_BYTES and SECTOR_BYTES are powers of two.
//
module flash_page_write_combiner #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096,
    parameter int BEAT_BYTES   = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // address[31:0], data_byte[39:32]
    input  logic [1:0]   s_axis_tuser,   // command[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // flash_address[31:0], beat_data[95:32],
                                         // byte_count[104:96], bytes_total[136:105]
    output logic [1:0]   m_axis_tuser,   // op_kind[1:0]
    output logic         m_axis_tlast
);

    localparam int WORDS   = (PAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
    localparam int WORDS_P = (WORDS > 1) ? (1 << $clog2(WORDS)) : 2;
    localparam int DEPTH   = 2 * WORDS_P;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIDTH   = 8 * BEAT_BYTES;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WIDTH-1:0]    ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WIDTH-1:0]    ram_rdata;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    fpwc_pkg::job_t      q_job;
    fpwc_pkg::job_t      q_head;
    fpwc_pkg::done_t     done;

    fpwc_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BEAT_BYTES   (BEAT_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .q_push        (q_push),
        .q_job         (q_job),
        .q_full        (q_full),
        .done          (done)
    );

    fpwc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // two page banks of beat-wide words
    fpwc_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpwc_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .BEAT_BYTES (BEAT_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .done          (done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
